// ===== sv/union_find_set_table_unit_assert.svh =====
// assertion macros shared by the union-find table checker
`ifndef UNION_FIND_SET_TABLE_UNIT_ASSERT_SVH
`define UNION_FIND_SET_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UFST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UFST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define UFST_ASSERT_NXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ufst_pkg.sv =====
// shared types and constants of the union-find set table
`default_nettype none

package ufst_pkg;

    localparam int IDX_W    = 10;
    localparam int EXT_W    = 17;
    localparam int RANK_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic rd_start;
        logic up_step;
        logic cmp_step;
        logic sel_second;
        logic merge_link;
        logic merge_rank;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic at_root;
        logic node_is_start;
        logic cmp_last;
        logic is_unite;
        logic roots_equal;
        logic grow;
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/ufst_ctrl.sv =====
// sequencer of the union-find set table: clearing pass, root walks, compression, merge
`default_nettype none

module ufst_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_tvalid,
    output logic          o_s_tready,
    input  ufst_pkg::t_sts i_sts,
    output ufst_pkg::t_cmd o_cmd
);
    import ufst_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR      = 11'b000_0000_0001,
        S_IDLE       = 11'b000_0000_0010,
        S_UP_LOAD    = 11'b000_0000_0100,
        S_UP         = 11'b000_0000_1000,
        S_CMP_LOAD   = 11'b000_0001_0000,
        S_CMP        = 11'b000_0010_0000,
        S_SECOND     = 11'b000_0100_0000,
        S_RESOLVE    = 11'b000_1000_0000,
        S_MERGE_LINK = 11'b001_0000_0000,
        S_MERGE_RANK = 11'b010_0000_0000,
        S_DONE       = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state, find_next;
    logic   r_second, n_second;

    always_comb begin
        if (!i_sts.is_unite) begin
            find_next = S_DONE;
        end else if (!r_second) begin
            find_next = S_SECOND;
        end else begin
            find_next = S_RESOLVE;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_second   = r_second;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_second     = 1'b0;
                    n_state      = S_UP_LOAD;
                end
            end
            S_UP_LOAD: begin
                o_cmd.rd_start = 1'b1;
                n_state        = S_UP;
            end
            S_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_sts.at_root) begin
                    n_state = i_sts.node_is_start ? find_next : S_CMP_LOAD;
                end
            end
            S_CMP_LOAD: begin
                o_cmd.rd_start = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_step = 1'b1;
                if (i_sts.cmp_last) begin
                    n_state = find_next;
                end
            end
            S_SECOND: begin
                o_cmd.sel_second = 1'b1;
                n_second         = 1'b1;
                n_state          = S_UP_LOAD;
            end
            S_RESOLVE: begin
                n_state = i_sts.roots_equal ? S_DONE : S_MERGE_LINK;
            end
            S_MERGE_LINK: begin
                o_cmd.merge_link = 1'b1;
                n_state          = i_sts.grow ? S_MERGE_RANK : S_DONE;
            end
            S_MERGE_RANK: begin
                o_cmd.merge_rank = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ufst_dpath.sv =====
// datapath of the union-find set table: link/rank memory, walk registers, result register
`default_nettype none

module ufst_dpath #(
    parameter int ELEMENT_COUNT = 1024
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ufst_pkg::t_cmd                 i_cmd,
    output ufst_pkg::t_sts                 o_sts,
    input  wire [ufst_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  wire [0:0]                      i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [ufst_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [0:0]                     o_m_tuser
);
    import ufst_pkg::*;

    localparam int IW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam int WW = IW + RANK_W;
    localparam logic [IW-1:0]    LAST  = IW'(ELEMENT_COUNT - 1);
    localparam logic [EXT_W-1:0] COUNT = EXT_W'(ELEMENT_COUNT);

    // word layout: rank in the upper bits, parent link in the lower bits
    logic [WW-1:0] mem [ELEMENT_COUNT];

    logic [WW-1:0]     r_rdata;
    logic [IW-1:0]     r_clr;
    logic              r_func;
    logic [IW-1:0]     r_start, r_b, r_node, r_root, r_ra;
    logic [RANK_W-1:0] r_root_rank, r_ra_rank;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_root;
    logic              r_out_merged;

    logic [EXT_W-1:0]  a_ext, b_ext;
    logic [IW-1:0]     a_idx, b_idx;
    logic [IW-1:0]     rd_link;
    logic [RANK_W-1:0] rd_rank;
    logic              at_root, rb_wins, roots_equal;
    logic [IW-1:0]     winner, loser, res_root;
    logic [RANK_W-1:0] w_rank, l_rank;
    logic              wr_en, rd_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [WW-1:0]     wr_data;

    // out-of-range indexes saturate to the last element
    assign a_ext = {(EXT_W - IDX_W)'(0), i_s_tdata[IDX_W-1:0]};
    assign b_ext = {(EXT_W - IDX_W)'(0), i_s_tdata[2*IDX_W-1:IDX_W]};
    assign a_idx = (a_ext >= COUNT) ? LAST : IW'(a_ext);
    assign b_idx = (b_ext >= COUNT) ? LAST : IW'(b_ext);

    assign rd_link = r_rdata[IW-1:0];
    assign rd_rank = r_rdata[IW +: RANK_W];
    assign at_root = (rd_link == r_node);

    // root of lower rank goes under the other, first root wins a tie
    assign rb_wins     = (r_ra_rank < r_root_rank);
    assign winner      = rb_wins ? r_root : r_ra;
    assign loser       = rb_wins ? r_ra : r_root;
    assign w_rank      = rb_wins ? r_root_rank : r_ra_rank;
    assign l_rank      = rb_wins ? r_ra_rank : r_root_rank;
    assign roots_equal = (r_ra == r_root);

    always_comb begin
        if (!r_func) begin
            res_root = r_root;
        end else if (roots_equal) begin
            res_root = r_ra;
        end else begin
            res_root = winner;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = {RANK_W'(0), r_clr};
        if (i_cmd.clear_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.cmp_step) begin
            wr_en   = 1'b1;
            wr_addr = r_node;
            wr_data = {rd_rank, r_root};
        end else if (i_cmd.merge_link) begin
            wr_en   = 1'b1;
            wr_addr = loser;
            wr_data = {l_rank, winner};
        end else if (i_cmd.merge_rank) begin
            wr_en   = 1'b1;
            wr_addr = winner;
            wr_data = {w_rank + RANK_W'(1), winner};
        end
    end

    assign rd_en   = i_cmd.rd_start | (i_cmd.up_step & ~at_root) | i_cmd.cmp_step;
    assign rd_addr = i_cmd.rd_start ? r_start : rd_link;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_s_tuser[0];
            r_start <= a_idx;
            r_b     <= b_idx;
        end
        if (i_cmd.rd_start) begin
            r_node <= r_start;
        end
        if (i_cmd.up_step) begin
            if (at_root) begin
                r_root      <= r_node;
                r_root_rank <= rd_rank;
            end else begin
                r_node <= rd_link;
            end
        end
        if (i_cmd.cmp_step) begin
            r_node <= rd_link;
        end
        if (i_cmd.sel_second) begin
            r_ra      <= r_root;
            r_ra_rank <= r_root_rank;
            r_start   <= r_b;
        end
        if (i_cmd.out_load) begin
            r_out_root   <= IDX_W'(res_root);
            r_out_merged <= r_func & ~roots_equal;
        end
    end

    assign o_sts.clr_last      = (r_clr == LAST);
    assign o_sts.at_root       = at_root;
    assign o_sts.node_is_start = (r_node == r_start);
    assign o_sts.cmp_last      = (rd_link == r_root);
    assign o_sts.is_unite      = r_func;
    assign o_sts.roots_equal   = roots_equal;
    assign o_sts.grow          = (r_ra_rank == r_root_rank) && (w_rank != RANK_MAX);
    assign o_sts.out_full      = r_out_valid & ~i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_DATA_W - IDX_W)'(0), r_out_root};
    assign o_m_tuser  = r_out_merged;

endmodule

`default_nettype wire

// ===== sv/union_find_set_table_unit.sv =====
// top level of the union-find set table with path compression and union by rank
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tuser: func; tdata: first_index, second_index
//  m       | out | o_m_tvalid/i_m_tready  | tuser: merged; tdata: root
//
//  after reset a clearing pass writes every link and rank
//  find walks to the root, then points a path of nonzero depth straight at the root
//  unite walks both, then links distinct roots and grows a tied rank below the maximum
//  each link step uses the single read port of the link/rank memory
//  one request is in work at a time; it is taken while the previous result still waits
//  a stalled result holds the block in its last state until the output register frees
`default_nettype none

module union_find_set_table_unit #(
    parameter int ELEMENT_COUNT = 1024
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire [ufst_pkg::S_DATA_W-1:0]   i_s_tdata,  // first_index, second_index, zero pad
    input  wire [0:0]                      i_s_tuser,  // func
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [ufst_pkg::M_DATA_W-1:0]  o_m_tdata,  // root, zero pad
    output logic [0:0]                     o_m_tuser   // merged
);
    import ufst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ufst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ufst_dpath #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/ufst_checker.sv =====
// port-level checks of the union-find set table, bound to the top level
`default_nettype none

`include "union_find_set_table_unit_assert.svh"

module ufst_checker #(
    parameter int ELEMENT_COUNT = 1024
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        i_s_tready,
    input wire        i_m_tvalid,
    input wire        i_m_tready,
    input wire [15:0] i_m_tdata
);

    // ready is low right after reset, when the clearing pass begins
    `UFST_ASSERT_NXT_RST(a_clear_blocks, !i_rst_n, !i_s_tready, "ready right after reset")

    // one request in work at a time
    `UFST_ASSERT_NXT(a_one_in_work, i_s_tvalid && i_s_tready, !i_s_tready,
        "ready again right after a request")

    // a stalled result holds
    `UFST_ASSERT_NXT(a_out_hold, i_m_tvalid && !i_m_tready,
        i_m_tvalid && $stable(i_m_tdata), "stalled result changed")

    // a root is always an element of the table
    `UFST_ASSERT_IMP(a_root_range, i_m_tvalid,
        ({7'd0, i_m_tdata[9:0]} < 17'(ELEMENT_COUNT)) && (i_m_tdata[15:10] == 6'd0),
        "root outside the table")

endmodule

bind union_find_set_table_unit ufst_checker #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
) u_ufst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== bench/tb_union_find_set_table_unit.sv =====
// self-checking testbench for the union-find set table with compressing finds and ranked unites
module tb_union_find_set_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ufst_pkg::*;

    localparam int ELEMENTS    = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int REPORT_MAX  = 10;

    typedef enum logic {
        OP_FIND  = 1'b0,
        OP_UNITE = 1'b1
    } t_op;

    typedef struct packed {
        logic [IDX_W-1:0] root;
        logic             merged;
    } t_set_result;

    class union_find_scoreboard;
        logic [IDX_W-1:0]  link_of [ELEMENTS];
        logic [RANK_W-1:0] rank_of [ELEMENTS];
        t_set_result       expected_q [$];
        int mismatches;
        int finds;
        int unites;
        int joins;
        int checked;
        int deepest_walk;
        int highest_rank;

        function new();
            for (int i = 0; i < ELEMENTS; i++) begin
                link_of[i] = IDX_W'(i);
                rank_of[i] = '0;
            end
            mismatches   = 0;
            finds        = 0;
            unites       = 0;
            joins        = 0;
            checked      = 0;
            deepest_walk = 0;
            highest_rank = 0;
        endfunction

        // walk up to the root, then point the walked path straight at it
        function logic [IDX_W-1:0] root_with_compression(logic [IDX_W-1:0] start);
            logic [IDX_W-1:0] node;
            logic [IDX_W-1:0] top;
            logic [IDX_W-1:0] next_node;
            int               depth;
            node  = start;
            depth = 0;
            while (link_of[node] != node) begin
                node  = link_of[node];
                depth = depth + 1;
            end
            top = node;
            if (depth > deepest_walk) deepest_walk = depth;
            node = start;
            while (node != top) begin
                next_node     = link_of[node];
                link_of[node] = top;
                node          = next_node;
            end
            return top;
        endfunction

        function void note_request(t_op op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
            t_set_result      res;
            logic [IDX_W-1:0] ra;
            logic [IDX_W-1:0] rb;
            logic [IDX_W-1:0] swap;
            res.merged = 1'b0;
            if (op == OP_FIND) begin
                finds    = finds + 1;
                res.root = root_with_compression(a);
            end else begin
                unites = unites + 1;
                ra     = root_with_compression(a);
                rb     = root_with_compression(b);
                if (ra == rb) begin
                    res.root = ra;
                end else begin
                    if (rank_of[ra] < rank_of[rb]) begin
                        swap = ra;
                        ra   = rb;
                        rb   = swap;
                    end
                    link_of[rb] = ra;
                    if (rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX) begin
                        rank_of[ra] = rank_of[ra] + 1'b1;
                    end
                    if (int'(rank_of[ra]) > highest_rank) highest_rank = int'(rank_of[ra]);
                    res.root   = ra;
                    res.merged = 1'b1;
                    joins      = joins + 1;
                end
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(logic [IDX_W-1:0] root, logic merged);
            t_set_result want;
            if (expected_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: unexpected result root=%0d merged=%0b", $realtime, root, merged);
                end
                return;
            end
            want    = expected_q.pop_front();
            checked = checked + 1;
            if (want.root !== root || want.merged !== merged) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: result %0d mismatch: root exp %0d got %0d, merged exp %0b got %0b",
                             $realtime, checked, want.root, root, want.merged, merged);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;  // first_index, second_index, zero pad
    logic [0:0]          i_s_tuser;  // func
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;  // root, zero pad
    logic [0:0]          o_m_tuser;  // merged

    union_find_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int stall_cycles;
    bit hold_request;

    union_find_set_table_unit #(
        .ELEMENT_COUNT(ELEMENTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    task automatic send_request(t_op op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {{(S_DATA_W - 2 * IDX_W){1'b0}}, b, a};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, a, b);
        items_sent = items_sent + 1;
    endtask

    // tournament of equal-rank unites over a block of 2**levels elements, then finds on it
    task automatic build_tree(int levels);
        int base;
        int lvl;
        int grp;
        int half;
        base = $urandom_range(ELEMENTS - (1 << levels));
        for (lvl = 0; lvl < levels; lvl++) begin
            half = 1 << lvl;
            for (grp = 0; grp + 2 * half <= (1 << levels); grp += 2 * half) begin
                send_request(OP_UNITE, IDX_W'(base + grp + $urandom_range(half - 1)),
                             IDX_W'(base + grp + half + $urandom_range(half - 1)));
            end
        end
        repeat ($urandom_range(2, 6)) begin
            send_request(OP_FIND, IDX_W'(base + $urandom_range((1 << levels) - 1)),
                         IDX_W'($urandom));
        end
    endtask

    task automatic run_random(int target);
        int pick;
        logic [IDX_W-1:0] a;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            a    = IDX_W'($urandom);
            if (pick < 20) begin
                build_tree($urandom_range(1, 4));
            end else if (pick < 60) begin
                send_request(OP_FIND, a, IDX_W'($urandom));
            end else if (pick < 90) begin
                send_request(OP_UNITE, a, IDX_W'($urandom));
            end else if (pick < 95) begin
                send_request(OP_UNITE, a, a);
            end else begin
                send_request(t_op'($urandom_range(1)), $urandom_range(1) ? '1 : '0,
                             $urandom_range(1) ? '1 : '0);
            end
        end
    endtask

    task automatic run_directed();
        send_request(OP_FIND, 10'd0, 10'd1023);
        send_request(OP_FIND, 10'd1023, 10'd0);
        send_request(OP_UNITE, 10'd0, 10'd0);
        send_request(OP_UNITE, 10'd0, 10'd1);
        send_request(OP_UNITE, 10'd2, 10'd3);
        send_request(OP_UNITE, 10'd0, 10'd2);
        send_request(OP_UNITE, 10'd4, 10'd5);
        send_request(OP_UNITE, 10'd6, 10'd7);
        send_request(OP_UNITE, 10'd6, 10'd4);
        send_request(OP_UNITE, 10'd3, 10'd5);
        send_request(OP_FIND, 10'd5, 10'd0);
        send_request(OP_FIND, 10'd3, 10'd682);
        send_request(OP_UNITE, 10'd1023, 10'd7);
        send_request(OP_UNITE, 10'd1, 10'd1022);
        send_request(OP_UNITE, 10'd7, 10'd1);
        send_request(OP_FIND, 10'd1023, 10'd341);
        send_request(OP_UNITE, 10'd512, 10'd511);
        send_request(OP_UNITE, 10'd1022, 10'd511);
        send_request(OP_FIND, 10'd511, 10'd1023);
        send_request(OP_FIND, 10'd1022, 10'd512);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready   = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            i_m_tready = ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata[IDX_W-1:0], o_m_tuser[0]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        i_m_tready    = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 72;
        items_sent    = 0;
        stall_cycles  = 0;
        hold_request  = 1'b0;
        sb            = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random(520);

        send_idle_pct = 72;
        recv_idle_pct = 11;
        run_random(1040);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        run_random(1550);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("run: %0d requests, %0d finds, %0d unites of which %0d joined sets, %0d checked",
                 items_sent, sb.finds, sb.unites, sb.joins, sb.checked);
        $display("run: deepest walk %0d links, highest rank %0d, %0d mismatches",
                 sb.deepest_walk, sb.highest_rank, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
